// File: rtl/fbcbm_pkg.sv
// fbcbm_pkg: shared types, constants and scoring helpers for the
// framebuffer format best-match block; no dependencies
package fbcbm_pkg;

  // desired-field encoding
  localparam int unsigned WantW     = 9;
  localparam int unsigned HaveW     = 8;
  localparam logic [WantW-1:0] DONT_CARE = 9'd511;

  // score widths and saturation limits
  localparam int unsigned MissW  = 5;
  localparam int unsigned ColorW = 18;
  localparam int unsigned ExtraW = 20;
  localparam logic [ColorW-1:0] COLOR_SAT = 18'd262143;
  localparam logic [ExtraW-1:0] EXTRA_SAT = 20'd1048575;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_COLOR = 3'd0,
    CFG_EXTRA = 3'd1,
    CFG_ACCUM = 3'd2,
    CFG_AUX   = 3'd3,
    CFG_FLAGS = 3'd4
  } cfg_idx_e;

  // flag bit positions shared by wanted and candidate flags
  localparam int unsigned FlagStereo = 0;
  localparam int unsigned FlagDouble = 1;
  localparam int unsigned FlagSrgb   = 2;

  // one candidate's score
  typedef struct packed {
    logic              pass;
    logic [MissW-1:0]  missing;
    logic [ColorW-1:0] cdiff;
    logic [ExtraW-1:0] ediff;
  } score_t;

  // squared distance, zero for a don't-care field
  function automatic logic [ColorW-1:0] sq_dist(input logic [WantW-1:0] want,
                                                input logic [HaveW-1:0] have);
    logic [WantW-1:0] have_x;
    logic [WantW-1:0] d;
    have_x = {1'b0, have};
    d = (want >= have_x) ? (want - have_x) : (have_x - want);
    if (want == DONT_CARE) begin
      return '0;
    end
    return ColorW'(d * d);
  endfunction

  // wanted (neither zero nor don't care) but absent in the candidate
  function automatic logic is_missing(input logic [WantW-1:0] want,
                                      input logic [HaveW-1:0] have);
    return (want != '0) && (want != DONT_CARE) && (have == '0);
  endfunction

endpackage

// File: rtl/fbcbm_score.sv
// fbcbm_score: combinational scoring of one candidate format against the
// desired format; depends on fbcbm_pkg
module fbcbm_score (
  input  logic [26:0]          want_color_i,
  input  logic [35:0]          want_extra_i,
  input  logic [35:0]          want_accum_i,
  input  logic [3:0]           want_aux_i,
  input  logic [2:0]           want_flags_i,
  input  logic [23:0]          color_bits_i,
  input  logic [23:0]          alpha_depth_stencil_i,
  input  logic [31:0]          accum_bits_i,
  input  logic [3:0]           aux_buffers_i,
  input  logic [7:0]           sample_count_i,
  input  logic [2:0]           cand_flags_i,
  output fbcbm_pkg::score_t    score_o
);
  import fbcbm_pkg::*;

  logic [ColorW-1:0] csq [3];
  logic [ColorW-1:0] esq [8];
  logic [2:0]        miss_fld;
  logic [MissW-1:0]  miss_aux;
  logic [ColorW+1:0] cdiff_raw;
  logic [ExtraW+1:0] ediff_raw;
  logic              srgb_pen;

  // hard checks: stereo wanted, double-buffer must agree
  assign score_o.pass = !(want_flags_i[FlagStereo] && !cand_flags_i[FlagStereo]) &&
                        (want_flags_i[FlagDouble] == cand_flags_i[FlagDouble]);

  // per-channel squared distances
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csq[i] = sq_dist(want_color_i[i*WantW +: WantW], color_bits_i[i*HaveW +: HaveW]);
      esq[i] = sq_dist(want_extra_i[i*WantW +: WantW],
                       alpha_depth_stencil_i[i*HaveW +: HaveW]);
      miss_fld[i] = is_missing(want_extra_i[i*WantW +: WantW],
                               alpha_depth_stencil_i[i*HaveW +: HaveW]);
    end
    for (int j = 0; j < 4; j++) begin
      esq[3+j] = sq_dist(want_accum_i[j*WantW +: WantW], accum_bits_i[j*HaveW +: HaveW]);
    end
    esq[7] = sq_dist(want_extra_i[3*WantW +: WantW], sample_count_i);
  end

  // missing buffer count
  assign miss_aux = (aux_buffers_i < want_aux_i) ? MissW'(want_aux_i - aux_buffers_i) : '0;
  assign score_o.missing = MissW'(miss_fld[0]) + MissW'(miss_fld[1]) + MissW'(miss_fld[2]) +
                           MissW'(is_missing(want_extra_i[3*WantW +: WantW],
                                             sample_count_i)) + miss_aux;

  // summed distances plus sRGB penalty, with saturation
  assign srgb_pen  = want_flags_i[FlagSrgb] && !cand_flags_i[FlagSrgb];
  assign cdiff_raw = (ColorW+2)'(csq[0]) + (ColorW+2)'(csq[1]) + (ColorW+2)'(csq[2]);
  assign ediff_raw = (ExtraW+2)'(esq[0]) + (ExtraW+2)'(esq[1]) + (ExtraW+2)'(esq[2]) +
                     (ExtraW+2)'(esq[3]) + (ExtraW+2)'(esq[4]) + (ExtraW+2)'(esq[5]) +
                     (ExtraW+2)'(esq[6]) + (ExtraW+2)'(esq[7]) + (ExtraW+2)'(srgb_pen);

  assign score_o.cdiff = (cdiff_raw > (ColorW+2)'(COLOR_SAT)) ? COLOR_SAT
                                                              : ColorW'(cdiff_raw);
  assign score_o.ediff = (ediff_raw > (ExtraW+2)'(EXTRA_SAT)) ? EXTRA_SAT
                                                              : ExtraW'(ediff_raw);

endmodule

// File: rtl/framebuffer_config_best_match.sv
// framebuffer_config_best_match: top level, input register, score register,
// running best and result register; depends on fbcbm_pkg and fbcbm_score
//
// Usage: desired format is written through the cfg channel (index 0 color,
// 1 extra, 2 accum, 3 aux, 4 flags; other indexes ignored) while idle.
// Candidates stream on the in channel, one per transaction, the set closed by
// last_i. Each last candidate yields one transaction on the out channel with
// chosen_handle_o and found_o; the running best is then cleared for the next set.
// A last candidate goes through the input, score and result registers in turn.
// Throughput: one candidate per cycle, set by the three-stage pipeline
// (input register, scoring into score register, compare into best/result).
// Only a last candidate waits on a full, stalled result register; earlier
// candidates keep flowing into the running best meanwhile.
// Reset: configuration returns to its defaults, all stages empty, no best held.
module framebuffer_config_best_match (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [35:0] cfg_data_i,
  // candidate channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] color_bits_i,
  input  logic [23:0] alpha_depth_stencil_i,
  input  logic [31:0] accum_bits_i,
  input  logic [3:0]  aux_buffers_i,
  input  logic [7:0]  sample_count_i,
  input  logic [2:0]  cand_flags_i,
  input  logic [9:0]  handle_i,
  input  logic        last_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  chosen_handle_o,
  output logic        found_o
);
  import fbcbm_pkg::*;

  // configuration registers
  logic [26:0] want_color_q;
  logic [35:0] want_extra_q;
  logic [35:0] want_accum_q;
  logic [3:0]  want_aux_q;
  logic [2:0]  want_flags_q;

  // input stage
  logic        in_valid_q;
  logic [23:0] color_q;
  logic [23:0] ads_q;
  logic [31:0] accum_q;
  logic [3:0]  aux_q;
  logic [7:0]  samples_q;
  logic [2:0]  cflags_q;
  logic [9:0]  in_handle_q;
  logic        in_last_q;

  // score stage
  score_t      score_d;
  score_t      sc_score_q;
  logic        sc_valid_q;
  logic [9:0]  sc_handle_q;
  logic        sc_last_q;

  // running best and result
  logic              have_best_q;
  logic [MissW-1:0]  best_missing_q;
  logic [ColorW-1:0] best_cdiff_q;
  logic [ExtraW-1:0] best_ediff_q;
  logic [9:0]        best_handle_q;
  logic              out_valid_q;
  logic [9:0]        out_handle_q;
  logic              out_found_q;

  logic in_fire, sc_ready, sc_fire, in_adv, better, take, nxt_have;
  logic [9:0] nxt_handle;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_color_q <= 27'd2101256;
      want_extra_q <= 36'd2109448;
      want_accum_q <= '0;
      want_aux_q   <= '0;
      want_flags_q <= 3'd2;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COLOR: want_color_q <= cfg_data_i[26:0];
        CFG_EXTRA: want_extra_q <= cfg_data_i;
        CFG_ACCUM: want_accum_q <= cfg_data_i;
        CFG_AUX:   want_aux_q   <= cfg_data_i[3:0];
        CFG_FLAGS: want_flags_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: only a last item waits on a full result register
  assign sc_ready   = !(sc_valid_q && sc_last_q) || !out_valid_q || out_ready_i;
  assign sc_fire    = sc_valid_q && sc_ready;
  assign in_adv     = !sc_valid_q || sc_ready;
  assign in_ready_o = !in_valid_q || in_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      color_q     <= color_bits_i;
      ads_q       <= alpha_depth_stencil_i;
      accum_q     <= accum_bits_i;
      aux_q       <= aux_buffers_i;
      samples_q   <= sample_count_i;
      cflags_q    <= cand_flags_i;
      in_handle_q <= handle_i;
      in_last_q   <= last_i;
    end
  end

  // scoring
  fbcbm_score u_score (
    .want_color_i          (want_color_q),
    .want_extra_i          (want_extra_q),
    .want_accum_i          (want_accum_q),
    .want_aux_i            (want_aux_q),
    .want_flags_i          (want_flags_q),
    .color_bits_i          (color_q),
    .alpha_depth_stencil_i (ads_q),
    .accum_bits_i          (accum_q),
    .aux_buffers_i         (aux_q),
    .sample_count_i        (samples_q),
    .cand_flags_i          (cflags_q),
    .score_o               (score_d)
  );

  // score register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_valid_q <= 1'b0;
    end else if (in_adv) begin
      sc_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_q) begin
      sc_score_q  <= score_d;
      sc_handle_q <= in_handle_q;
      sc_last_q   <= in_last_q;
    end
  end

  // compare against running best, earlier candidate wins ties
  always_comb begin
    better = !have_best_q || (sc_score_q.missing < best_missing_q) ||
             ((sc_score_q.missing == best_missing_q) &&
              ((sc_score_q.cdiff < best_cdiff_q) ||
               ((sc_score_q.cdiff == best_cdiff_q) && (sc_score_q.ediff < best_ediff_q))));
    take       = sc_score_q.pass && better;
    nxt_have   = have_best_q || take;
    nxt_handle = take ? sc_handle_q : best_handle_q;
  end

  // running best update, cleared after a last item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q    <= 1'b0;
      best_missing_q <= '0;
      best_cdiff_q   <= '0;
      best_ediff_q   <= '0;
      best_handle_q  <= '0;
    end else if (sc_fire) begin
      if (sc_last_q) begin
        have_best_q    <= 1'b0;
        best_missing_q <= '0;
        best_cdiff_q   <= '0;
        best_ediff_q   <= '0;
        best_handle_q  <= '0;
      end else if (take) begin
        have_best_q    <= 1'b1;
        best_missing_q <= sc_score_q.missing;
        best_cdiff_q   <= sc_score_q.cdiff;
        best_ediff_q   <= sc_score_q.ediff;
        best_handle_q  <= sc_handle_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sc_fire && sc_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sc_fire && sc_last_q) begin
      out_handle_q <= nxt_have ? nxt_handle : '0;
      out_found_q  <= nxt_have;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_handle_o = out_handle_q;
  assign found_o         = out_found_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(sc_fire && sc_last_q))
    else $error("result register overwritten while stalled");

  // set boundary clears the running best
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc_fire && sc_last_q) |=> !have_best_q)
    else $error("running best not cleared after last candidate");

  // no match reports handle zero
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (chosen_handle_o == '0))
    else $error("nonzero handle without a match");

endmodule
